[hw/rtl/circular_deque_unit_defines.svh]
// ----------------------------------------------------------------------------
// Circular deque assertion macros
// Shared concurrent assertion wrappers for the deque RTL.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_DEQUE_UNIT_DEFINES_SVH
`define CIRCULAR_DEQUE_UNIT_DEFINES_SVH

// Check a property on the rising edge of a named clock, off while in reset.
`define CDQ_ASSERT_CLK(lbl, clk_sig, rst_sig, prop, msg) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Check a property on the block clock and reset.
`define CDQ_ASSERT(lbl, prop, msg) \
  `CDQ_ASSERT_CLK(lbl, clk, rst, prop, msg)

`endif

[hw/rtl/cdq_pkg.sv]
// ----------------------------------------------------------------------------
// Circular deque package
// Field widths, command codes and register map of the deque block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int CAP_W   = 11;
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;

  localparam logic [CAP_W-1:0]  CAP_RESET   = 11'd1024;
  localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

  // Register index, taken from the word address bit of paddr
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_NOP        = 3'd4
  } cmd_t;

endpackage

`default_nettype wire

[hw/rtl/cdq_cmd_if.sv]
// ----------------------------------------------------------------------------
// Circular deque command channel
// Valid/ready channel carrying one deque command transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdq_cmd_if;

  logic                              valid;
  logic                              ready;
  logic [cdq_pkg::CMD_W-1:0]         command;
  logic signed [cdq_pkg::DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);

endinterface

`default_nettype wire

[hw/rtl/cdq_rsp_if.sv]
// ----------------------------------------------------------------------------
// Circular deque response channel
// Valid/ready channel carrying one deque result transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cdq_rsp_if;

  logic                              valid;
  logic                              ready;
  logic                              accepted;
  logic signed [cdq_pkg::DATA_W-1:0] front_value;
  logic signed [cdq_pkg::DATA_W-1:0] rear_value;
  logic                              is_empty;
  logic                              is_full;

  modport source (
    output valid, output accepted, output front_value, output rear_value,
    output is_empty, output is_full, input ready
  );
  modport sink (
    input valid, input accepted, input front_value, input rear_value,
    input is_empty, input is_full, output ready
  );

endinterface

`default_nettype wire

[hw/rtl/cdq_ram.sv]
// ----------------------------------------------------------------------------
// Circular deque RAM
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

[hw/rtl/circular_deque_unit.sv]
// ----------------------------------------------------------------------------
// Circular deque unit: ring-buffer deque with configurable capacity.
// A command updates head, tail and the RAM; S_READ reads head and tail, S_DONE
// registers the result when rsp is free; next command only after that.
// Reset: empty deque, capacity 1024; store contents left as they are.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "circular_deque_unit_defines.svh"

module circular_deque_unit #(
  parameter int DEPTH = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  cdq_cmd_if.sink                      cmd,
  cdq_rsp_if.source                    rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdq_pkg::ADDR_W-1:0]   paddr,
  input  logic [cdq_pkg::PDATA_W-1:0]  pwdata,
  output logic [cdq_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  import cdq_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DONE
  } state_t;

  state_t            state;
  logic [CAP_W-1:0]  capacity;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic              empty_q;
  logic              ok_q;

  logic              rsp_valid;
  logic              rsp_accepted;
  logic [DATA_W-1:0] rsp_front;
  logic [DATA_W-1:0] rsp_rear;
  logic              rsp_empty;
  logic              rsp_full;

  logic [CW-1:0]     eff_cap;
  logic              full_now;
  logic              cmd_fire;
  logic              cfg_wr;

  logic [AW-1:0]     head_next;
  logic [AW-1:0]     tail_next;
  logic              empty_next;
  logic              ok_next;
  logic              push_we;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DATA_W-1:0] rd_front;
  logic [DATA_W-1:0] rd_rear;

  function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i, input logic [CW-1:0] cap);
    logic [CW:0] n;
    n = (CW+1)'(i) + (CW+1)'(1);
    return (n >= (CW+1)'(cap)) ? '0 : AW'(n);
  endfunction

  function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i, input logic [CW-1:0] cap);
    logic [CW:0] ie;
    ie = (CW+1)'(i);
    if (i == '0 || ie > (CW+1)'(cap)) begin
      return AW'(cap - CW'(1));
    end
    return i - AW'(1);
  endfunction

  // Clamp capacity to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CW'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      eff_cap = CW'(DEPTH);
    end else begin
      eff_cap = CW'(capacity);
    end
  end

  assign full_now = !empty_q && (idx_inc(tail, eff_cap) == head);
  assign cmd.ready = (state == S_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_CAPACITY);
  assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY) ? PDATA_W'(capacity) : '0;

  always_comb begin
    head_next  = head;
    tail_next  = tail;
    empty_next = empty_q;
    ok_next    = 1'b1;
    push_we    = 1'b0;
    ram_waddr  = head;
    unique case (cmd_t'(cmd.command))
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (full_now) begin
          ok_next = 1'b0;
        end else if (empty_q) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b0;
          push_we    = 1'b1;
          ram_waddr  = '0;
        end else if (cmd_t'(cmd.command) == CMD_PUSH_FRONT) begin
          head_next = idx_dec(head, eff_cap);
          push_we   = 1'b1;
          ram_waddr = head_next;
        end else begin
          tail_next = idx_inc(tail, eff_cap);
          push_we   = 1'b1;
          ram_waddr = tail_next;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty_q) begin
          ok_next = 1'b0;
        end else if (head == tail) begin
          head_next  = '0;
          tail_next  = '0;
          empty_next = 1'b1;
        end else if (cmd_t'(cmd.command) == CMD_POP_FRONT) begin
          head_next = idx_inc(head, eff_cap);
        end else begin
          tail_next = idx_dec(tail, eff_cap);
        end
      end
      default: begin
      end
    endcase
  end

  assign ram_we = cmd_fire && push_we;

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (DATA_W'(cmd.value)),
    .raddr_a (head),
    .rdata_a (rd_front),
    .raddr_b (tail),
    .rdata_b (rd_rear)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      capacity  <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      empty_q   <= 1'b1;
      ok_q      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp.ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_fire) begin
            head    <= head_next;
            tail    <= tail_next;
            empty_q <= empty_next;
            ok_q    <= ok_next;
            state   <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_valid    <= 1'b1;
            rsp_accepted <= ok_q;
            rsp_front    <= empty_q ? EMPTY_VALUE : rd_front;
            rsp_rear     <= empty_q ? EMPTY_VALUE : rd_rear;
            rsp_empty    <= empty_q;
            rsp_full     <= full_now;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Capacity write empties the deque
      if (cfg_wr) begin
        capacity <= pwdata[CAP_W-1:0];
        head     <= '0;
        tail     <= '0;
        empty_q  <= 1'b1;
      end
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.accepted    = rsp_accepted;
  assign rsp.front_value = rsp_front;
  assign rsp.rear_value  = rsp_rear;
  assign rsp.is_empty    = rsp_empty;
  assign rsp.is_full     = rsp_full;

  `CDQ_ASSERT(a_empty_idx, empty_q |-> (head == '0 && tail == '0), "nonzero index while empty")
  `CDQ_ASSERT(a_idx_range, !empty_q |-> (CW'(head) < eff_cap && CW'(tail) < eff_cap), "bad index")
  `CDQ_ASSERT(a_rsp_src, $rose(rsp.valid) |-> $past(state == S_DONE), "stray result")

endmodule

`default_nettype wire

[sim/circular_deque_unit_test.sv]
// ----------------------------------------------------------------------------
// Circular deque unit regression
// Drives push, pop and idle commands through the command channel, checks
// every result against a cycle-free deque predictor or directed row, and
// reprograms capacity over the APB port between phases, extremes included.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module circular_deque_unit_test;
  import cdq_pkg::*;

  localparam int RING_DEPTH = 1024;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_ITEMS = 1450;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 12;
  localparam int MAX_PRINTED = 40;
  localparam int CAP_MAX = (1 << CAP_W) - 1;

  localparam logic [ADDR_W-1:0] CAPACITY_ADDR = {REG_CAPACITY, 2'b00};

  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] front_value;
    logic [DATA_W-1:0] rear_value;
    logic              is_empty;
    logic              is_full;
  } deque_result_t;

  typedef enum logic {ROW_COMMAND, ROW_CAPACITY} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CMD_W-1:0]  code;
    logic [DATA_W-1:0] data;
    logic              typed;
    deque_result_t     want;
  } directed_row_t;

  typedef enum logic [1:0] {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;
  typedef enum logic [1:0] {RX_OPEN, RX_THREE_OF_FOUR, RX_COIN, RX_TWO_OF_SEVEN} rx_pattern_t;

  localparam deque_result_t RES_EMPTY_FAIL = '{1'b0, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0};
  localparam deque_result_t RES_EMPTY_OK   = '{1'b1, EMPTY_VALUE, EMPTY_VALUE, 1'b1, 1'b0};
  localparam deque_result_t NO_RESULT      = '0;
  localparam int NUM_DIRECTED_ROWS = 29;

  directed_row_t directed_rows [NUM_DIRECTED_ROWS] = '{
    '{ROW_COMMAND, CMD_POP_FRONT,  32'h0000_0000, 1'b1, RES_EMPTY_FAIL},
    '{ROW_COMMAND, CMD_POP_BACK,   32'h0000_0000, 1'b1, RES_EMPTY_FAIL},
    '{ROW_COMMAND, CMD_NOP,        32'h0000_0000, 1'b1, RES_EMPTY_OK},
    '{ROW_COMMAND, CMD_SPARE_7,    32'hFFFF_FFFF, 1'b1, RES_EMPTY_OK},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'h7FFF_FFFF, 1'b1,
      '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'h8000_0000, 1'b1,
      '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0}},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'hFFFF_FFFF, 1'b1,
      '{1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{ROW_COMMAND, CMD_SPARE_5,    32'h1234_5678, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_SPARE_6,    32'hDEAD_BEEF, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_BACK,   32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_BACK,   32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, CMD_NOP,       32'h0000_0001, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'hA5A5_A5A5, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, 1'b1}},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'h5A5A_5A5A, 1'b1,
      '{1'b0, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 1'b0, 1'b1}},
    '{ROW_COMMAND, CMD_POP_BACK,   32'h0000_0000, 1'b1, RES_EMPTY_OK},
    '{ROW_CAPACITY, CMD_NOP,       32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'h0000_0001, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'h0000_0002, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, CMD_NOP,       32'h0000_07FF, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'h0000_0003, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'h0000_0004, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_CAPACITY, CMD_NOP,       32'h0000_0002, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT},
    '{ROW_COMMAND, CMD_POP_FRONT,  32'h0000_0000, 1'b0, NO_RESULT}
  };

  logic [DATA_W-1:0] corner_values [4] = '{
    32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  cdq_cmd_if cmd_ch ();
  cdq_rsp_if rsp_ch ();

  circular_deque_unit #(
    .DEPTH(RING_DEPTH)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Deque predictor state
  logic [DATA_W-1:0] ring_mem [RING_DEPTH];
  int unsigned head_pos;
  int unsigned tail_pos;
  bit deque_empty;
  logic [CAP_W-1:0] cap_reg;

  deque_result_t expected_results [$];
  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned burst_left;
  int unsigned cycle_count;
  bit hold_request;

  function automatic int unsigned usable_depth();
    if (cap_reg == '0) return 1;
    if (cap_reg > RING_DEPTH) return RING_DEPTH;
    return cap_reg;
  endfunction

  function automatic int unsigned ring_next(input int unsigned pos);
    return (pos + 1 >= usable_depth()) ? 0 : pos + 1;
  endfunction

  function automatic int unsigned ring_prev(input int unsigned pos);
    if (pos == 0 || pos > usable_depth()) return usable_depth() - 1;
    return pos - 1;
  endfunction

  function automatic bit deque_full();
    return !deque_empty && ring_next(tail_pos) == head_pos;
  endfunction

  function automatic deque_result_t apply_command(input logic [CMD_W-1:0] code,
                                                  input logic [DATA_W-1:0] data);
    deque_result_t res;
    res.accepted = 1'b1;
    case (code)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (deque_full()) begin
          res.accepted = 1'b0;
        end else if (deque_empty) begin
          head_pos = 0;
          tail_pos = 0;
          deque_empty = 1'b0;
          ring_mem[0] = data;
        end else if (code == CMD_PUSH_FRONT) begin
          head_pos = ring_prev(head_pos);
          ring_mem[head_pos] = data;
        end else begin
          tail_pos = ring_next(tail_pos);
          ring_mem[tail_pos] = data;
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (deque_empty) begin
          res.accepted = 1'b0;
        end else if (head_pos == tail_pos) begin
          head_pos = 0;
          tail_pos = 0;
          deque_empty = 1'b1;
        end else if (code == CMD_POP_FRONT) begin
          head_pos = ring_next(head_pos);
        end else begin
          tail_pos = ring_prev(tail_pos);
        end
      end
      default: ;
    endcase
    res.front_value = deque_empty ? EMPTY_VALUE : ring_mem[head_pos];
    res.rear_value = deque_empty ? EMPTY_VALUE : ring_mem[tail_pos];
    res.is_empty = deque_empty;
    res.is_full = deque_full();
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
    if (mismatch_count < MAX_PRINTED)
      $display("mismatch at result %0d: %s got %h expected %h", result_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_command(input logic [CMD_W-1:0] code, input logic [DATA_W-1:0] data,
                              input bit typed, input deque_result_t typed_result);
    int unsigned gap;
    deque_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= code;
    cmd_ch.value <= data;
    do @(posedge clk); while (!cmd_ch.ready);
    predicted = apply_command(code, data);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic wait_results_drained();
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CAPACITY_ADDR;
    pwdata <= PDATA_W'(cap);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cap_reg = cap;
    head_pos = 0;
    tail_pos = 0;
    deque_empty = 1'b1;
    // read back
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(cap)) report_mismatch("capacity readback", prdata, PDATA_W'(cap));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("circular_deque_unit regression: fail");
    $finish;
  end

  // Result sink: stall on a changing pattern, hold off on request
  initial begin : result_sink
    rx_pattern_t pattern;
    int unsigned pattern_left;
    int unsigned pattern_phase;
    int unsigned hold_left;
    logic next_ready;
    rsp_ch.ready = 1'b0;
    pattern = RX_OPEN;
    pattern_left = 0;
    pattern_phase = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (pattern_left == 0) begin
        pattern = rx_pattern_t'($urandom_range(0, 3));
        pattern_left = $urandom_range(20, 200);
        pattern_phase = 0;
      end
      pattern_left--;
      pattern_phase++;
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else begin
        case (pattern)
          RX_OPEN:          next_ready = 1'b1;
          RX_THREE_OF_FOUR: next_ready = (pattern_phase % 4) != 3;
          RX_COIN:          next_ready = $urandom_range(0, 1);
          default:          next_ready = (pattern_phase % 7) < 2;
        endcase
      end
      rsp_ch.ready <= next_ready;
    end
  end

  always @(posedge clk) begin : result_check
    deque_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transaction", rsp_ch.front_value, EMPTY_VALUE);
      end else begin
        want = expected_results.pop_front();
        if (rsp_ch.accepted !== want.accepted)
          report_mismatch("accepted", DATA_W'(rsp_ch.accepted), DATA_W'(want.accepted));
        if (rsp_ch.front_value !== want.front_value)
          report_mismatch("front_value", rsp_ch.front_value, want.front_value);
        if (rsp_ch.rear_value !== want.rear_value)
          report_mismatch("rear_value", rsp_ch.rear_value, want.rear_value);
        if (rsp_ch.is_empty !== want.is_empty)
          report_mismatch("is_empty", DATA_W'(rsp_ch.is_empty), DATA_W'(want.is_empty));
        if (rsp_ch.is_full !== want.is_full)
          report_mismatch("is_full", DATA_W'(rsp_ch.is_full), DATA_W'(want.is_full));
      end
      result_count++;
    end
  end

  initial begin : stimulus
    int unsigned phase_idx;
    int unsigned phase_len;
    int unsigned random_sent;
    int unsigned push_pct;
    int unsigned pop_pct;
    int unsigned roll;
    logic [CMD_W-1:0] code;
    logic [DATA_W-1:0] data;
    logic [CAP_W-1:0] next_cap;
    mix_t mix;

    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = CMD_NOP;
    cmd_ch.value = '0;
    hold_request = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    burst_left = 0;
    cap_reg = CAP_RESET;
    head_pos = 0;
    tail_pos = 0;
    deque_empty = 1'b1;
    foreach (ring_mem[i]) ring_mem[i] = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CAPACITY) begin
        cmd_ch.valid <= 1'b0;
        wait_results_drained();
        write_capacity(directed_rows[i].data[CAP_W-1:0]);
      end else begin
        send_command(directed_rows[i].code, directed_rows[i].data,
                     directed_rows[i].typed, directed_rows[i].want);
      end
    end

    phase_idx = 0;
    random_sent = 0;
    mix = MIX_BALANCED;
    while (random_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       next_cap = '0;
        1:       next_cap = CAP_W'(1);
        2:       next_cap = CAP_W'(2);
        3:       next_cap = CAP_RESET;
        4:       next_cap = CAP_W'(CAP_MAX);
        5:       next_cap = CAP_W'($urandom_range(RING_DEPTH + 1, CAP_MAX));
        6, 7:    next_cap = CAP_W'($urandom_range(3, 12));
        8:       next_cap = CAP_W'($urandom_range(13, 64));
        default: next_cap = CAP_W'($urandom_range(0, CAP_MAX));
      endcase
      // hold until idle, then reprogram
      cmd_ch.valid <= 1'b0;
      wait_results_drained();
      write_capacity(next_cap);
      if (phase_idx % 5 == 1) hold_request = 1'b1;
      phase_len = $urandom_range(30, 140);
      for (int k = 0; k < phase_len && random_sent < RANDOM_ITEMS; k++) begin
        if (k % 24 == 0) mix = mix_t'($urandom_range(0, 2));
        case (mix)
          MIX_FILL:  begin push_pct = 75; pop_pct = 20; end
          MIX_DRAIN: begin push_pct = 20; pop_pct = 75; end
          default:   begin push_pct = 45; pop_pct = 45; end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
          code = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        else if (roll < push_pct + pop_pct)
          code = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
        else
          code = CMD_W'($urandom_range(CMD_NOP, CMD_SPARE_7));
        data = ($urandom_range(0, 7) == 0) ? corner_values[$urandom_range(0, 3)] : $urandom();
        send_command(code, data, 1'b0, NO_RESULT);
        random_sent++;
      end
      phase_idx++;
    end

    cmd_ch.valid <= 1'b0;
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("circular_deque_unit regression: pass");
    end else begin
      $display("circular_deque_unit regression: fail");
    end
    $finish;
  end

endmodule

[circular_deque_unit.f]
+incdir+hw/rtl
hw/rtl/cdq_pkg.sv
hw/rtl/cdq_cmd_if.sv
hw/rtl/cdq_rsp_if.sv
hw/rtl/cdq_ram.sv
hw/rtl/circular_deque_unit.sv
sim/circular_deque_unit_test.sv
